FILE: hdl/gsp_pkg.sv
// Package for the gray stretch and posterize core.
// Holds the constants, register indexes, state type and divider status type.
// Used by gsp_div, gray_stretch_posterize_core and gsp_chk.
package gsp_pkg;

	localparam logic [7:0] LOW_THR  = 8'd30;
	localparam logic [7:0] HIGH_THR = 8'd225;
	localparam logic [7:0] FULL     = 8'd255;
	localparam logic [7:0] STEP_NUM = 8'd195;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd3;

	localparam logic MODE_MEASURE = 1'b0;
	localparam logic MODE_MAP     = 1'b1;

	localparam logic [7:0]  LEVELS_RST = 8'd8;
	localparam logic [7:0]  STEP_RST   = 8'd24;
	localparam logic [11:0] GAIN_RST   = 12'd256;
	localparam logic [8:0]  OFFSET_RST = 9'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP,
		ST_PREP,
		ST_SDIV,
		ST_GAIN,
		ST_RND,
		ST_POST,
		ST_PDIV,
		ST_QUANT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hdl/gsp_div.sv
// Shared restoring divider producing an 8-bit quotient, one bit per cycle.
// The dividend's upper byte must be below the divisor. Depends on gsp_pkg.
module gsp_div
	import gsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [7:0]  divisor,
	output div_stat_t   stat,
	output logic [7:0]  quotient
);

	logic [7:0] rem_q;
	logic [7:0] sh_q;
	logic [7:0] den_q;
	logic [2:0] cnt_q;
	logic       busy_q;
	logic       done_q;
	logic [8:0] trial;
	logic       qbit;
	logic [7:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, sh_q[7]};
		qbit    = (trial >= {1'b0, den_q});
		rem_nxt = qbit ? 8'(trial - {1'b0, den_q}) : trial[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[15:8];
			sh_q  <= dividend[7:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			sh_q  <= {sh_q[6:0], qbit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = sh_q;

endmodule

FILE: hdl/gray_stretch_posterize_core.sv
// Top level of the gray stretch and posterize core.
// Depends on gsp_pkg and the shared divider gsp_div.
//
// Pixels arrive on the s_ stream: s_tdata holds the pixel, s_tuser holds the
// mode (measure or map) and the frame start flag. A measure transaction
// updates the running minimum and maximum and yields no result; the core stays
// in its idle state. A map transaction yields one posterized level on the m_ stream.
// A map pixel runs through one divider that gives one quotient bit a cycle:
// setup, the stretch division, the gain multiply and rounding, the posterize
// compare, the posterize division, quantization and the output step, which
// raises m_tvalid; s_tready stays low meanwhile, so the core takes no new
// pixel before the last map pixel is through. A flat range skips the stretch
// division and a level outside the thresholds skips the posterize division
// and quantization. Writing level_count starts a step division that keeps
// s_tready low until it completes. The result sits in an output register, so
// the next pixel is accepted while it waits; a stalled receiver holds m_tdata
// and the next map pixel waits at its last step until the register frees.
// Reset clears the minimum to 255, the maximum to 0 and the registers to
// invert 0, level_count 8, contrast_gain 256 and contrast_offset 0.
module gray_stretch_posterize_core
	import gsp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [7:0] pixel
	input  logic [1:0]            s_tuser,  // [0] mode, [1] frame_start
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata   // [7:0] level
);

	state_t      state_q, state_n;
	logic        invert_q;
	logic [7:0]  levels_q;
	logic [11:0] gain_q;
	logic [8:0]  offset_q;
	logic [7:0]  step_q;
	logic        step_pend_q;
	logic [7:0]  min_q;
	logic [7:0]  max_q;
	logic [7:0]  pix_q;
	logic [7:0]  s_q;
	logic [19:0] prod_q;
	logic [7:0]  v_q;
	logic [7:0]  res_q;
	logic [7:0]  k_q;
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;

	logic        in_acc;
	logic [7:0]  pix_in;
	logic        out_free;
	logic        flat;
	logic [7:0]  pix_c;
	logic [7:0]  diff;
	logic        post_low;
	logic        post_high;
	logic [21:0] sum;
	logic [12:0] rq;
	logic        rup;
	logic [13:0] rq1;
	logic [7:0]  vrnd;
	logic [15:0] kstep;
	logic [16:0] knext;
	logic [7:0]  quant;

	logic        div_start;
	logic [15:0] div_dividend;
	logic [7:0]  div_divisor;
	div_stat_t   div_stat;
	logic [7:0]  div_quo;

	gsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_comb begin
		in_acc    = s_tvalid && s_tready;
		pix_in    = invert_q ? ~s_tdata : s_tdata;
		out_free  = !m_tvalid_q || m_tready;
		flat      = (max_q <= min_q);
		pix_c     = (pix_q < min_q) ? min_q : ((pix_q > max_q) ? max_q : pix_q);
		diff      = pix_c - min_q;
		post_low  = (v_q < LOW_THR);
		post_high = (v_q > HIGH_THR);
		sum       = 22'({2'b00, prod_q}) + {{5{offset_q[8]}}, offset_q, 8'd0};
		rq        = sum[20:8];
		rup       = (sum[7:0] > 8'd128) || ((sum[7:0] == 8'd128) && rq[0]);
		rq1       = {1'b0, rq} + {13'd0, rup};
		if (sum[21] || (sum == '0)) begin
			vrnd = 8'd0;
		end else if (rq1 > 14'({FULL})) begin
			vrnd = FULL;
		end else begin
			vrnd = rq1[7:0];
		end
		kstep = {8'd0, k_q} * {8'd0, step_q};
		knext = {1'b0, kstep} + {9'd0, step_q} + {9'd0, LOW_THR};
		quant = (knext < 17'({HIGH_THR})) ? 8'(kstep + {8'd0, LOW_THR}) : HIGH_THR;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (step_pend_q) begin
					state_n = ST_STEP;
				end else if (in_acc && (s_tuser[0] == MODE_MAP)) begin
					state_n = ST_PREP;
				end
			end
			ST_STEP: begin
				if (div_stat.done) begin
					state_n = ST_IDLE;
				end
			end
			ST_PREP:  state_n = flat ? ST_GAIN : ST_SDIV;
			ST_SDIV: begin
				if (div_stat.done) begin
					state_n = ST_GAIN;
				end
			end
			ST_GAIN:  state_n = ST_RND;
			ST_RND:   state_n = ST_POST;
			ST_POST:  state_n = (post_low || post_high) ? ST_FIN : ST_PDIV;
			ST_PDIV: begin
				if (div_stat.done) begin
					state_n = ST_QUANT;
				end
			end
			ST_QUANT: state_n = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = step_q;
		case (state_q)
			ST_IDLE: begin
				s_tready     = !step_pend_q;
				div_start    = step_pend_q;
				div_dividend = {8'd0, STEP_NUM};
				div_divisor  = (levels_q == 8'd0) ? 8'd1 : levels_q;
			end
			ST_PREP: begin
				div_start    = !flat;
				div_dividend = {diff, 8'd0} - {8'd0, diff};
				div_divisor  = max_q - min_q;
			end
			ST_POST: begin
				div_start    = !(post_low || post_high);
				div_dividend = {8'd0, 8'(v_q - LOW_THR)};
				div_divisor  = step_q;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			invert_q    <= 1'b0;
			levels_q    <= LEVELS_RST;
			gain_q      <= GAIN_RST;
			offset_q    <= OFFSET_RST;
			step_q      <= STEP_RST;
			step_pend_q <= 1'b0;
			min_q       <= FULL;
			max_q       <= 8'd0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				case (cfg_index)
					CFG_INVERT: invert_q <= cfg_data[0];
					CFG_LEVELS: begin
						levels_q    <= cfg_data[7:0];
						step_pend_q <= 1'b1;
					end
					CFG_GAIN:   gain_q   <= cfg_data[11:0];
					CFG_OFFSET: offset_q <= cfg_data[8:0];
					default:    invert_q <= invert_q;
				endcase
			end else if ((state_q == ST_IDLE) && step_pend_q) begin
				step_pend_q <= 1'b0;
			end
			if ((state_q == ST_STEP) && div_stat.done) begin
				step_q <= (div_quo == 8'd0) ? 8'd1 : div_quo;
			end
			if (in_acc && (s_tuser[0] == MODE_MEASURE)) begin
				if (s_tuser[1]) begin
					min_q <= pix_in;
					max_q <= pix_in;
				end else begin
					if (pix_in < min_q) begin
						min_q <= pix_in;
					end
					if (pix_in > max_q) begin
						max_q <= pix_in;
					end
				end
			end
			if ((state_q == ST_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q <= pix_in;
		end
		if ((state_q == ST_PREP) && flat) begin
			s_q <= 8'd0;
		end else if ((state_q == ST_SDIV) && div_stat.done) begin
			s_q <= div_quo;
		end
		if (state_q == ST_GAIN) begin
			prod_q <= {12'd0, s_q} * {8'd0, gain_q};
		end
		if (state_q == ST_RND) begin
			v_q <= vrnd;
		end
		if (state_q == ST_POST) begin
			res_q <= post_low ? 8'd0 : FULL;
		end
		if ((state_q == ST_PDIV) && div_stat.done) begin
			k_q <= div_quo;
		end
		if (state_q == ST_QUANT) begin
			res_q <= quant;
		end
		if ((state_q == ST_FIN) && out_free) begin
			m_tdata_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: hdl/gsp_chk.sv
// Port-level checker for gray_stretch_posterize_core, bound to the top level.
// Depends on gsp_pkg.
module gsp_chk
	import gsp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Output transaction changed while stalled.");

	a_map_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == MODE_MAP) |=> !s_tready)
		else $error("Input accepted again right after a map transaction.");

	a_measure_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == MODE_MEASURE) && !cfg_we |=> s_tready)
		else $error("Measure transaction did not complete in one cycle.");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == 8'd0) || (m_tdata == FULL) ||
			((m_tdata >= LOW_THR) && (m_tdata <= HIGH_THR)))
		else $error("Output level outside the posterized range.");

endmodule

bind gray_stretch_posterize_core gsp_chk u_gsp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tuser   (s_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
